// ===== rtl/sgr_at_pkg.sv =====
// shared types, code constants and the 256-entry colour palette for the sgr attribute tracker
package sgr_at_pkg;

   typedef logic [23:0] color_type;
   typedef color_type palette_type [256];

   // sub-state of an extended colour (38/48/58)
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_MODE  = 3'd1,
      PH_INDEX = 3'd2,
      PH_RED   = 3'd3,
      PH_GREEN = 3'd4,
      PH_BLUE  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      TGT_FG    = 2'd0,
      TGT_BG    = 2'd1,
      TGT_DECOR = 2'd2
   } target_type;

   typedef enum logic [1:0] {
      CSR_DEFAULT_FG    = 2'd0,
      CSR_DEFAULT_BG    = 2'd1,
      CSR_DEFAULT_DECOR = 2'd2,
      CSR_BOLD_BRIGHT   = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic strike;
      logic inverse;
      logic blink;
      logic underline;
      logic italic;
      logic dim;
      logic bold;
   } attr_type;

   typedef struct packed {
      color_type default_fg;
      color_type default_bg;
      color_type default_decor;
      logic      bold_is_bright;
   } cfg_type;

   typedef struct packed {
      color_type fg;
      color_type bg;
      color_type decor;
      attr_type  flags;
      logic      done;
   } rsp_type;

   localparam color_type RESET_DEFAULT_FG    = 24'hCCCCCC;
   localparam color_type RESET_DEFAULT_BG    = 24'h0C0C0C;
   localparam color_type RESET_DEFAULT_DECOR = 24'hCCCCCC;

   // sgr parameter codes
   localparam logic [15:0] SGR_RESET       = 16'd0;
   localparam logic [15:0] SGR_BOLD        = 16'd1;
   localparam logic [15:0] SGR_DIM         = 16'd2;
   localparam logic [15:0] SGR_ITALIC      = 16'd3;
   localparam logic [15:0] SGR_UNDERLINE   = 16'd4;
   localparam logic [15:0] SGR_BLINK       = 16'd5;
   localparam logic [15:0] SGR_INVERSE     = 16'd7;
   localparam logic [15:0] SGR_STRIKE      = 16'd9;
   localparam logic [15:0] SGR_NO_BOLD     = 16'd21;
   localparam logic [15:0] SGR_NORMAL      = 16'd22;
   localparam logic [15:0] SGR_NO_ITALIC   = 16'd23;
   localparam logic [15:0] SGR_NO_UNDER    = 16'd24;
   localparam logic [15:0] SGR_NO_BLINK    = 16'd25;
   localparam logic [15:0] SGR_NO_INVERSE  = 16'd27;
   localparam logic [15:0] SGR_NO_STRIKE   = 16'd29;
   localparam logic [15:0] SGR_EXT_FG      = 16'd38;
   localparam logic [15:0] SGR_EXT_BG      = 16'd48;
   localparam logic [15:0] SGR_EXT_DECOR   = 16'd58;
   localparam logic [15:0] SGR_DEF_FG      = 16'd39;
   localparam logic [15:0] SGR_DEF_BG      = 16'd49;
   localparam logic [15:0] SGR_DEF_DECOR   = 16'd59;
   localparam logic [15:0] SGR_FG_FIRST    = 16'd30;
   localparam logic [15:0] SGR_FG_LAST     = 16'd37;
   localparam logic [15:0] SGR_BG_FIRST    = 16'd40;
   localparam logic [15:0] SGR_BG_LAST     = 16'd47;
   localparam logic [15:0] SGR_FGB_FIRST   = 16'd90;
   localparam logic [15:0] SGR_FGB_LAST    = 16'd97;
   localparam logic [15:0] SGR_BGB_FIRST   = 16'd100;
   localparam logic [15:0] SGR_BGB_LAST    = 16'd107;
   localparam logic [15:0] MODE_INDEXED    = 16'd5;
   localparam logic [15:0] MODE_DIRECT     = 16'd2;

   localparam color_type BASIC_PALETTE [16] = '{
      24'h0C0C0C, 24'hC50F1F, 24'h13A10E, 24'hC19C00,
      24'h0037DA, 24'h881798, 24'h3A96DD, 24'hCCCCCC,
      24'h767676, 24'hE74856, 24'h16C60C, 24'hF9F1A5,
      24'h3B78FF, 24'hB4009E, 24'h61D6D6, 24'hF2F2F2
   };

   localparam int GREY_FIRST = 232;
   localparam int GREY_BASE  = 8;
   localparam int GREY_STEP  = 10;
   localparam int CUBE_FIRST = 16;
   localparam int CUBE_BASE  = 55;
   localparam int CUBE_STEP  = 40;
   localparam int CUBE_SIDE  = 6;
   localparam int CUBE_PLANE = 36;

   function automatic logic [7:0] cube_level(input int lvl);
      int v;
      v = (lvl == 0) ? 0 : CUBE_BASE + lvl * CUBE_STEP;
      return 8'(v);
   endfunction

   // evaluated at elaboration only
   function automatic palette_type build_palette();
      palette_type p;
      int n;
      int c;
      int g;
      for (n = 0; n < 256; n++) begin
         if (n < CUBE_FIRST) begin
            p[n] = BASIC_PALETTE[n];
         end else if (n >= GREY_FIRST) begin
            g = GREY_BASE + (n - GREY_FIRST) * GREY_STEP;
            p[n] = {8'(g), 8'(g), 8'(g)};
         end else begin
            c = n - CUBE_FIRST;
            p[n] = {cube_level(c / CUBE_PLANE), cube_level((c / CUBE_SIDE) % CUBE_SIDE),
                    cube_level(c % CUBE_SIDE)};
         end
      end
      return p;
   endfunction

   localparam palette_type PALETTE = build_palette();

endpackage

// ===== rtl/sgr_at_palette.sv =====
// 256-colour palette lookup with index saturation
module sgr_at_palette
   import sgr_at_pkg::*;
(
   input  logic [15:0] value,
   output color_type   color
);

   logic [7:0] index;

   // indices above 255 saturate
   assign index = (|value[15:8]) ? 8'hFF : value[7:0];
   assign color = PALETTE[index];

endmodule

// ===== rtl/sgr_at_core.sv =====
// attribute state registers and the per-parameter update logic
module sgr_at_core
   import sgr_at_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [15:0] value,
   input  logic        last,
   input  cfg_type     cfg,
   output rsp_type     result
);

   color_type  fg_ff, fg_in;
   color_type  bg_ff, bg_in;
   color_type  decor_ff, decor_in;
   attr_type   flags_ff, flags_in;
   phase_type  phase_ff, phase_in, phase_mid;
   target_type target_ff, target_in;
   logic [7:0] red_ff, red_in;
   logic [7:0] green_ff, green_in;

   logic       early_end;
   logic       plain_en;
   logic       ext_apply;
   color_type  ext_color;
   color_type  index_color;
   color_type  fg_p, bg_p, decor_p;
   attr_type   flags_p;
   logic [15:0] fg_off, bg_off, fgb_off, bgb_off;

   sgr_at_palette u_palette (
      .value (value),
      .color (index_color)
   );

   // next state of the extended colour sub-state
   always_comb begin
      phase_mid = PH_IDLE;
      target_in = target_ff;
      case (phase_ff)
         PH_MODE: begin
            if (value == MODE_INDEXED) begin
               phase_mid = PH_INDEX;
            end else if (value == MODE_DIRECT) begin
               phase_mid = PH_RED;
            end
         end
         PH_INDEX: phase_mid = PH_IDLE;
         PH_RED:   phase_mid = PH_GREEN;
         PH_GREEN: phase_mid = PH_BLUE;
         PH_BLUE:  phase_mid = PH_IDLE;
         default: begin
            if (value == SGR_EXT_FG) begin
               target_in = TGT_FG;
               phase_mid = PH_MODE;
            end else if (value == SGR_EXT_BG) begin
               target_in = TGT_BG;
               phase_mid = PH_MODE;
            end else if (value == SGR_EXT_DECOR) begin
               target_in = TGT_DECOR;
               phase_mid = PH_MODE;
            end
         end
      endcase
      early_end = last && (phase_mid != PH_IDLE);
      phase_in  = early_end ? PH_IDLE : phase_mid;
   end

   // extended colour write and component holds
   always_comb begin
      plain_en  = 1'b0;
      ext_apply = 1'b0;
      ext_color = cfg.default_fg;
      red_in    = red_ff;
      green_in  = green_ff;
      case (phase_ff)
         PH_MODE:  ext_apply = (value != MODE_INDEXED) && (value != MODE_DIRECT);
         PH_INDEX: begin
            ext_apply = 1'b1;
            ext_color = index_color;
         end
         PH_RED:   red_in = value[7:0];
         PH_GREEN: green_in = value[7:0];
         PH_BLUE: begin
            ext_apply = 1'b1;
            ext_color = {red_ff, green_ff, value[7:0]};
         end
         default:  plain_en = 1'b1;
      endcase
      // sequence ended with the colour incomplete
      if (early_end) begin
         ext_apply = 1'b1;
         ext_color = cfg.default_fg;
      end
   end

   assign fg_off  = value - SGR_FG_FIRST;
   assign bg_off  = value - SGR_BG_FIRST;
   assign fgb_off = value - SGR_FGB_FIRST;
   assign bgb_off = value - SGR_BGB_FIRST;

   // plain codes
   always_comb begin
      fg_p    = fg_ff;
      bg_p    = bg_ff;
      decor_p = decor_ff;
      flags_p = flags_ff;
      if (plain_en) begin
         case (value)
            SGR_RESET: begin
               fg_p    = cfg.default_fg;
               bg_p    = cfg.default_bg;
               decor_p = cfg.default_decor;
               flags_p = '0;
            end
            SGR_BOLD:      flags_p.bold = 1'b1;
            SGR_DIM:       flags_p.dim = 1'b1;
            SGR_ITALIC:    flags_p.italic = 1'b1;
            SGR_UNDERLINE: flags_p.underline = 1'b1;
            SGR_BLINK:     flags_p.blink = 1'b1;
            SGR_INVERSE: begin
               if (!flags_ff.inverse) begin
                  flags_p.inverse = 1'b1;
                  fg_p = bg_ff;
                  bg_p = fg_ff;
               end
            end
            SGR_STRIKE:    flags_p.strike = 1'b1;
            SGR_NO_BOLD:   flags_p.bold = 1'b0;
            SGR_NORMAL: begin
               flags_p.bold = 1'b0;
               flags_p.dim  = 1'b0;
            end
            SGR_NO_ITALIC: flags_p.italic = 1'b0;
            SGR_NO_UNDER:  flags_p.underline = 1'b0;
            SGR_NO_BLINK:  flags_p.blink = 1'b0;
            SGR_NO_INVERSE: begin
               if (flags_ff.inverse) begin
                  flags_p.inverse = 1'b0;
                  fg_p = bg_ff;
                  bg_p = fg_ff;
               end
            end
            SGR_NO_STRIKE: flags_p.strike = 1'b0;
            SGR_DEF_FG: begin
               fg_p    = cfg.default_fg;
               decor_p = cfg.default_decor;
            end
            SGR_DEF_BG:    bg_p = cfg.default_bg;
            SGR_DEF_DECOR: decor_p = cfg.default_decor;
            default: begin
               if (value >= SGR_FG_FIRST && value <= SGR_FG_LAST) begin
                  fg_p = BASIC_PALETTE[{cfg.bold_is_bright && flags_ff.bold, fg_off[2:0]}];
                  decor_p = fg_p;
               end else if (value >= SGR_BG_FIRST && value <= SGR_BG_LAST) begin
                  bg_p = BASIC_PALETTE[{1'b0, bg_off[2:0]}];
               end else if (value >= SGR_FGB_FIRST && value <= SGR_FGB_LAST) begin
                  fg_p = BASIC_PALETTE[{1'b1, fgb_off[2:0]}];
                  decor_p = fg_p;
               end else if (value >= SGR_BGB_FIRST && value <= SGR_BGB_LAST) begin
                  bg_p = BASIC_PALETTE[{1'b1, bgb_off[2:0]}];
               end
            end
         endcase
      end
   end

   // extended colour lands on its target after any plain update
   always_comb begin
      fg_in    = fg_p;
      bg_in    = bg_p;
      decor_in = decor_p;
      flags_in = flags_p;
      if (ext_apply) begin
         case (target_in)
            TGT_FG: begin
               fg_in    = ext_color;
               decor_in = ext_color;
            end
            TGT_BG:  bg_in = ext_color;
            default: decor_in = ext_color;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fg_ff     <= RESET_DEFAULT_FG;
         bg_ff     <= RESET_DEFAULT_BG;
         decor_ff  <= RESET_DEFAULT_DECOR;
         flags_ff  <= '0;
         phase_ff  <= PH_IDLE;
         target_ff <= TGT_FG;
         red_ff    <= '0;
         green_ff  <= '0;
      end else if (step) begin
         fg_ff     <= fg_in;
         bg_ff     <= bg_in;
         decor_ff  <= decor_in;
         flags_ff  <= flags_in;
         phase_ff  <= phase_in;
         target_ff <= target_in;
         red_ff    <= red_in;
         green_ff  <= green_in;
      end
   end

   assign result.fg    = fg_in;
   assign result.bg    = bg_in;
   assign result.decor = decor_in;
   assign result.flags = flags_in;
   assign result.done  = last;

`ifndef SYNTHESIS
   a_last_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      step && last |=> phase_ff == PH_IDLE)
      else $error("sub-state not idle after last parameter");

   a_inverse_swaps: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_IDLE && value == SGR_INVERSE && !flags_ff.inverse
      |=> fg_ff == $past(bg_ff) && bg_ff == $past(fg_ff) && flags_ff.inverse)
      else $error("inverse did not swap colours");

   a_direct_mode: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_MODE && value == MODE_DIRECT && !last
      |=> phase_ff == PH_RED)
      else $error("direct colour mode not entered");
`endif

endmodule

// ===== rtl/sgr_attribute_tracker.sv =====
// top level of the sgr attribute tracker: input register, settings registers, result register
//
// usage
//    req_*  : one sgr parameter per transaction (req_param_value, req_last_param flags the
//             final parameter of a sequence); valid/ready handshake
//    rsp_*  : one result per parameter, the whole attribute set after that parameter,
//             rsp_sequence_done repeats the last-parameter flag; valid/ready handshake
//    csr_*  : write-only settings port, csr_index selects default fg, default bg, default
//             decoration or bold-is-bright; writes take effect at once; the user must make
//             them only while no transaction is in flight; the block does not enforce this
// timing
//    a parameter is captured in the input register at its accepting edge, goes through the
//    combinational update logic and lands in the result register once that register is free
//    or being emptied; one parameter per cycle sustained while rsp_ready stays high, set by
//    the single update stage
// reset (synchronous, active high) empties both registers, loads the default settings,
// sets the colours to those defaults and clears all flags and any pending extended colour
// when the receiver stalls the result is held; the input register still takes one more
// transaction, then req_ready drops until the result is taken
module sgr_attribute_tracker
   import sgr_at_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [15:0] req_param_value,
   input  logic        req_last_param,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_fg_color,
   output logic [23:0] rsp_bg_color,
   output logic [23:0] rsp_decor_color,
   output logic        rsp_bold_on,
   output logic        rsp_dim_on,
   output logic        rsp_italic_on,
   output logic        rsp_underline_on,
   output logic        rsp_blink_on,
   output logic        rsp_inverse_on,
   output logic        rsp_strike_on,
   output logic        rsp_sequence_done,

   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data
);

   // settings
   cfg_type     cfg_ff;

   // input register
   logic        in_valid_ff;
   logic [15:0] in_value_ff;
   logic        in_last_ff;

   // result register
   logic        out_valid_ff;
   rsp_type     out_ff;
   rsp_type     result;

   logic        advance;

   // the update stage moves on whenever the result register is free or being emptied
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.default_fg     <= RESET_DEFAULT_FG;
         cfg_ff.default_bg     <= RESET_DEFAULT_BG;
         cfg_ff.default_decor  <= RESET_DEFAULT_DECOR;
         cfg_ff.bold_is_bright <= 1'b0;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_DEFAULT_FG:    cfg_ff.default_fg <= csr_write_data;
            CSR_DEFAULT_BG:    cfg_ff.default_bg <= csr_write_data;
            CSR_DEFAULT_DECOR: cfg_ff.default_decor <= csr_write_data;
            CSR_BOLD_BRIGHT:   cfg_ff.bold_is_bright <= csr_write_data[0];
            default:           cfg_ff <= cfg_ff;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_value_ff <= req_param_value;
         in_last_ff  <= req_last_param;
      end
   end

   sgr_at_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .value  (in_value_ff),
      .last   (in_last_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_fg_color      = out_ff.fg;
   assign rsp_bg_color      = out_ff.bg;
   assign rsp_decor_color   = out_ff.decor;
   assign rsp_bold_on       = out_ff.flags.bold;
   assign rsp_dim_on        = out_ff.flags.dim;
   assign rsp_italic_on     = out_ff.flags.italic;
   assign rsp_underline_on  = out_ff.flags.underline;
   assign rsp_blink_on      = out_ff.flags.blink;
   assign rsp_inverse_on    = out_ff.flags.inverse;
   assign rsp_strike_on     = out_ff.flags.strike;
   assign rsp_sequence_done = out_ff.done;

`ifndef SYNTHESIS
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with an empty result register");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && out_valid_ff)
      else $error("input stalled without a held transaction");

   a_advance_gives_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("update step produced no result");
`endif

endmodule

// ===== dv/sgr_result_checker.sv =====
// checker for the sgr attribute tracker: predicts every result and compares it field by field
module sgr_result_checker
   import sgr_at_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_param_value,
   input  logic        req_last_param,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [23:0] rsp_fg_color,
   input  logic [23:0] rsp_bg_color,
   input  logic [23:0] rsp_decor_color,
   input  logic        rsp_bold_on,
   input  logic        rsp_dim_on,
   input  logic        rsp_italic_on,
   input  logic        rsp_underline_on,
   input  logic        rsp_blink_on,
   input  logic        rsp_inverse_on,
   input  logic        rsp_strike_on,
   input  logic        rsp_sequence_done,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_write_data,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CUBE_BYTES [6] = '{8'd0, 8'd95, 8'd135, 8'd175, 8'd215, 8'd255};

   cfg_type    cfg;
   color_type  fg_now;
   color_type  bg_now;
   color_type  decor_now;
   attr_type   flags_now;
   phase_type  phase;
   target_type target;
   logic [7:0] red_held;
   logic [7:0] green_held;
   rsp_type    attr_q [$];

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(input string name, input logic [23:0] got,
                                input logic [23:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d %s is %06h, expected %06h",
                                   checked_count, name, got, want));
   endtask

   function automatic color_type indexed_color(input logic [15:0] n);
      int idx;
      int c;
      int g;
      idx = (n > 16'd255) ? 255 : int'(n);
      if (idx < CUBE_FIRST) return BASIC_PALETTE[idx];
      if (idx >= GREY_FIRST) begin
         g = GREY_BASE + (idx - GREY_FIRST) * GREY_STEP;
         return {8'(g), 8'(g), 8'(g)};
      end
      c = idx - CUBE_FIRST;
      return {CUBE_BYTES[c / CUBE_PLANE], CUBE_BYTES[(c / CUBE_SIDE) % CUBE_SIDE],
              CUBE_BYTES[c % CUBE_SIDE]};
   endfunction

   function automatic void paint(input color_type c);
      case (target)
         TGT_FG: begin
            fg_now = c;
            decor_now = c;
         end
         TGT_BG: bg_now = c;
         default: decor_now = c;
      endcase
   endfunction

   function automatic void swap_fg_bg();
      color_type held;
      held = fg_now;
      fg_now = bg_now;
      bg_now = held;
   endfunction

   function automatic void apply_code(input logic [15:0] v);
      logic [3:0] idx;
      case (v)
         SGR_RESET: begin
            fg_now = cfg.default_fg;
            bg_now = cfg.default_bg;
            decor_now = cfg.default_decor;
            flags_now = '0;
         end
         SGR_BOLD:      flags_now.bold = 1'b1;
         SGR_DIM:       flags_now.dim = 1'b1;
         SGR_ITALIC:    flags_now.italic = 1'b1;
         SGR_UNDERLINE: flags_now.underline = 1'b1;
         SGR_BLINK:     flags_now.blink = 1'b1;
         SGR_INVERSE: begin
            if (!flags_now.inverse) begin
               flags_now.inverse = 1'b1;
               swap_fg_bg();
            end
         end
         SGR_STRIKE:    flags_now.strike = 1'b1;
         SGR_NO_BOLD:   flags_now.bold = 1'b0;
         SGR_NORMAL: begin
            flags_now.bold = 1'b0;
            flags_now.dim = 1'b0;
         end
         SGR_NO_ITALIC: flags_now.italic = 1'b0;
         SGR_NO_UNDER:  flags_now.underline = 1'b0;
         SGR_NO_BLINK:  flags_now.blink = 1'b0;
         SGR_NO_INVERSE: begin
            if (flags_now.inverse) begin
               flags_now.inverse = 1'b0;
               swap_fg_bg();
            end
         end
         SGR_NO_STRIKE: flags_now.strike = 1'b0;
         SGR_EXT_FG: begin
            target = TGT_FG;
            phase = PH_MODE;
         end
         SGR_EXT_BG: begin
            target = TGT_BG;
            phase = PH_MODE;
         end
         SGR_EXT_DECOR: begin
            target = TGT_DECOR;
            phase = PH_MODE;
         end
         SGR_DEF_FG: begin
            fg_now = cfg.default_fg;
            decor_now = cfg.default_decor;
         end
         SGR_DEF_BG:    bg_now = cfg.default_bg;
         SGR_DEF_DECOR: decor_now = cfg.default_decor;
         default: begin
            if (v >= SGR_FG_FIRST && v <= SGR_FG_LAST) begin
               idx = 4'(v - SGR_FG_FIRST);
               if (cfg.bold_is_bright && flags_now.bold) idx = idx + 4'd8;
               fg_now = BASIC_PALETTE[idx];
               decor_now = fg_now;
            end else if (v >= SGR_BG_FIRST && v <= SGR_BG_LAST) begin
               idx = 4'(v - SGR_BG_FIRST);
               bg_now = BASIC_PALETTE[idx];
            end else if (v >= SGR_FGB_FIRST && v <= SGR_FGB_LAST) begin
               idx = 4'(v - SGR_FGB_FIRST) + 4'd8;
               fg_now = BASIC_PALETTE[idx];
               decor_now = fg_now;
            end else if (v >= SGR_BGB_FIRST && v <= SGR_BGB_LAST) begin
               idx = 4'(v - SGR_BGB_FIRST) + 4'd8;
               bg_now = BASIC_PALETTE[idx];
            end
         end
      endcase
   endfunction

   // attribute set after one parameter
   function automatic rsp_type next_attributes(input logic [15:0] v, input logic last);
      rsp_type r;
      case (phase)
         PH_MODE: begin
            if (v == MODE_INDEXED) begin
               phase = PH_INDEX;
            end else if (v == MODE_DIRECT) begin
               phase = PH_RED;
            end else begin
               paint(cfg.default_fg);
               phase = PH_IDLE;
            end
         end
         PH_INDEX: begin
            paint(indexed_color(v));
            phase = PH_IDLE;
         end
         PH_RED: begin
            red_held = v[7:0];
            phase = PH_GREEN;
         end
         PH_GREEN: begin
            green_held = v[7:0];
            phase = PH_BLUE;
         end
         PH_BLUE: begin
            paint({red_held, green_held, v[7:0]});
            phase = PH_IDLE;
         end
         default: begin
            phase = PH_IDLE;
            apply_code(v);
         end
      endcase
      // sequence ended with an extended colour still open
      if (last && phase != PH_IDLE) begin
         paint(cfg.default_fg);
         phase = PH_IDLE;
      end
      r.fg = fg_now;
      r.bg = bg_now;
      r.decor = decor_now;
      r.flags = flags_now;
      r.done = last;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type oldest;
      if (reset) begin
         cfg.default_fg = RESET_DEFAULT_FG;
         cfg.default_bg = RESET_DEFAULT_BG;
         cfg.default_decor = RESET_DEFAULT_DECOR;
         cfg.bold_is_bright = 1'b0;
         fg_now = RESET_DEFAULT_FG;
         bg_now = RESET_DEFAULT_BG;
         decor_now = RESET_DEFAULT_DECOR;
         flags_now = '0;
         phase = PH_IDLE;
         target = TGT_FG;
         red_held = '0;
         green_held = '0;
         attr_q.delete();
         fail_count = 0;
         checked_count = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (attr_q.size() == 0) begin
               report_mismatch("result transaction with no parameter outstanding");
            end else begin
               oldest = attr_q.pop_front();
               compare_field("fg_color", rsp_fg_color, oldest.fg);
               compare_field("bg_color", rsp_bg_color, oldest.bg);
               compare_field("decor_color", rsp_decor_color, oldest.decor);
               compare_field("bold_on", 24'(rsp_bold_on), 24'(oldest.flags.bold));
               compare_field("dim_on", 24'(rsp_dim_on), 24'(oldest.flags.dim));
               compare_field("italic_on", 24'(rsp_italic_on), 24'(oldest.flags.italic));
               compare_field("underline_on", 24'(rsp_underline_on),
                             24'(oldest.flags.underline));
               compare_field("blink_on", 24'(rsp_blink_on), 24'(oldest.flags.blink));
               compare_field("inverse_on", 24'(rsp_inverse_on), 24'(oldest.flags.inverse));
               compare_field("strike_on", 24'(rsp_strike_on), 24'(oldest.flags.strike));
               compare_field("sequence_done", 24'(rsp_sequence_done), 24'(oldest.done));
               checked_count++;
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_DEFAULT_FG:    cfg.default_fg = csr_write_data;
               CSR_DEFAULT_BG:    cfg.default_bg = csr_write_data;
               CSR_DEFAULT_DECOR: cfg.default_decor = csr_write_data;
               CSR_BOLD_BRIGHT:   cfg.bold_is_bright = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            attr_q.insert(attr_q.size(), next_attributes(req_param_value, req_last_param));
      end
      pending_count = attr_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// top of the sgr attribute tracker testbench: clock, reset, stimulus, stall pattern and verdict
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sgr_at_pkg::*;

   // cycles without any transaction before the run is declared hung
   localparam int STALL_LIMIT = 2000;
   // random parameters per settings round, and number of rounds
   localparam int ROUND_ITEMS = 100;
   localparam int ROUNDS = 5;

   // directed parameters: bit 16 marks the final parameter of a sequence
   localparam int unsigned LAST = 32'h1_0000;
   localparam int DIRECTED_LEN = 32;
   localparam int unsigned DIRECTED [DIRECTED_LEN] = '{
      // every attribute on, inverse swap, then a bold colour with bold-is-bright set
      SGR_BOLD, SGR_DIM, SGR_ITALIC, SGR_UNDERLINE, SGR_BLINK, SGR_STRIKE, SGR_INVERSE,
      LAST | SGR_FG_LAST,
      // truecolour background with wide components, decoration with an unknown mode (7),
      // palette foreground with an index past the end, then inverse off
      SGR_EXT_BG, MODE_DIRECT, 65535, 0, 511, SGR_EXT_DECOR, 7,
      SGR_EXT_FG, MODE_INDEXED, 300, LAST | SGR_NO_INVERSE,
      // the clear codes other than inverse off, the three default colours, full reset,
      // and a truecolour foreground cut short by the end of the sequence
      SGR_NO_BOLD, SGR_NORMAL, SGR_NO_ITALIC, SGR_NO_UNDER, SGR_NO_BLINK, SGR_NO_STRIKE,
      SGR_DEF_FG, SGR_DEF_BG, SGR_DEF_DECOR, SGR_RESET, SGR_EXT_FG, MODE_DIRECT, LAST | 10
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_param_value = '0;
   logic        req_last_param = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_fg_color;
   logic [23:0] rsp_bg_color;
   logic [23:0] rsp_decor_color;
   logic        rsp_bold_on;
   logic        rsp_dim_on;
   logic        rsp_italic_on;
   logic        rsp_underline_on;
   logic        rsp_blink_on;
   logic        rsp_inverse_on;
   logic        rsp_strike_on;
   logic        rsp_sequence_done;
   logic        csr_write_en = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [23:0] csr_write_data = '0;

   int fail_count;
   int pending_count;
   int checked_count;

   // run statistics for the closing summary
   int n_params = 0;
   int n_random = 0;
   int n_sequences = 0;
   int n_ext = 0;
   int n_settings = 0;
   // the sender idles only while this is set; one round runs back to back
   bit sender_idles = 1'b1;

   sgr_attribute_tracker i_dut (.*);

   sgr_result_checker i_checker (.*);

   // 4 ns clock
   initial begin
      forever #2 clock = ~clock;
   end

   // gap length: mostly none, often a few cycles, now and then a long one
   function automatic int pick_gap(input bit enable);
      int r;
      if (!enable) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // offer one parameter and hold it until the transaction completes;
   // entered and left at a falling edge, left with req_valid still high
   task automatic send_param(input logic [15:0] value, input logic last);
      int gap;
      gap = pick_gap(sender_idles);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_param_value <= value;
      req_last_param <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      n_params++;
      if (last) n_sequences++;
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // one write per cycle, all four registers back to back
   task automatic apply_settings(input color_type fg_def, input color_type bg_def,
                                 input color_type decor_def, input logic bright);
      csr_write_en <= 1'b1;
      csr_index <= CSR_DEFAULT_FG;
      csr_write_data <= fg_def;
      @(negedge clock);
      csr_index <= CSR_DEFAULT_BG;
      csr_write_data <= bg_def;
      @(negedge clock);
      csr_index <= CSR_DEFAULT_DECOR;
      csr_write_data <= decor_def;
      @(negedge clock);
      csr_index <= CSR_BOLD_BRIGHT;
      csr_write_data <= {23'd0, bright};
      @(negedge clock);
      csr_write_en <= 1'b0;
      n_settings++;
   endtask

   // colour component: mostly a byte, sometimes a full 16-bit value to exercise the
   // truncation to the low 8 bits
   function automatic logic [15:0] pick_component();
      if ($urandom_range(0, 99) < 85) return 16'($urandom_range(0, 255));
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic logic [15:0] pick_ext_code();
      case ($urandom_range(0, 2))
         0: return SGR_EXT_FG;
         1: return SGR_EXT_BG;
         default: return SGR_EXT_DECOR;
      endcase
   endfunction

   // mostly handled plain codes; the first two groups also hit the ignored 6, 8, 26 and 28
   function automatic logic [15:0] pick_plain_code();
      case ($urandom_range(0, 6))
         0: return 16'($urandom_range(0, 9));
         1: return 16'($urandom_range(21, 29));
         2: return 16'($urandom_range(SGR_FG_FIRST, SGR_FG_LAST));
         3: return 16'($urandom_range(SGR_BG_FIRST, SGR_BG_LAST));
         4: return 16'($urandom_range(SGR_FGB_FIRST, SGR_FGB_LAST));
         5: return 16'($urandom_range(SGR_BGB_FIRST, SGR_BGB_LAST));
         default: begin
            case ($urandom_range(0, 2))
               0: return SGR_DEF_FG;
               1: return SGR_DEF_BG;
               default: return SGR_DEF_DECOR;
            endcase
         end
      endcase
   endfunction

   // build one sequence of a few parts and send it with the last flag on its final
   // parameter; most parts are well formed, the rest noise or broken extended colours
   task automatic send_random_sequence();
      logic [15:0] params [$];
      int parts;
      int kind;
      int depth;
      bit cut;
      parts = $urandom_range(1, 4);
      cut = 1'b0;
      for (int p = 0; p < parts && !cut; p++) begin
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            params.insert(params.size(), pick_plain_code());
         end else if (kind < 78) begin
            params.insert(params.size(), pick_ext_code());
            n_ext++;
            if ($urandom_range(0, 1)) begin
               params.insert(params.size(), MODE_INDEXED);
               params.insert(params.size(),
                             $urandom_range(0, 9) < 9 ? 16'($urandom_range(0, 255))
                                                      : 16'($urandom_range(0, 65535)));
            end else begin
               params.insert(params.size(), MODE_DIRECT);
               repeat (3) params.insert(params.size(), pick_component());
            end
         end else if (kind < 88) begin
            // noise: any value at all, most of them ignored codes
            params.insert(params.size(),
                          $urandom_range(0, 1) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 120)));
         end else begin
            params.insert(params.size(), pick_ext_code());
            n_ext++;
            depth = $urandom_range(0, 5);
            case (depth)
               0: cut = 1'b1;
               1: begin
                  params.insert(params.size(), MODE_INDEXED);
                  cut = 1'b1;
               end
               2: begin
                  params.insert(params.size(), MODE_DIRECT);
                  cut = 1'b1;
               end
               3: begin
                  params.insert(params.size(), MODE_DIRECT);
                  params.insert(params.size(), pick_component());
                  cut = 1'b1;
               end
               4: begin
                  params.insert(params.size(), MODE_DIRECT);
                  params.insert(params.size(), pick_component());
                  params.insert(params.size(), pick_component());
                  cut = 1'b1;
               end
               // unknown mode: consumed, sequence goes on
               default: params.insert(params.size(), 16'($urandom_range(0, 65535)));
            endcase
         end
      end
      foreach (params[i]) begin
         send_param(params[i], i == params.size() - 1);
         n_random++;
      end
   endtask

   // result side: ready high for a stretch, then a stall of random length
   initial begin
      int run_len;
      int stall_len;
      forever begin
         run_len = $urandom_range(1, 40);
         stall_len = pick_gap(1'b1);
         repeat (run_len) begin
            @(negedge clock);
            rsp_ready <= 1'b1;
         end
         repeat (stall_len) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
      end
   end

   // watchdog: any transaction on either channel restarts the count
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
               STALL_LIMIT, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // main stimulus
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // random defaults with bold-is-bright set, so the directed bold colour brightens
      apply_settings(24'($urandom), 24'($urandom), 24'($urandom), 1'b1);
      for (int i = 0; i < DIRECTED_LEN; i++)
         send_param(16'(DIRECTED[i]), (DIRECTED[i] & LAST) != 0);

      for (int round = 0; round < ROUNDS; round++) begin
         // settings change only with nothing in flight
         wait_for_results();
         case (round)
            1: apply_settings(24'h000000, 24'h000000, 24'h000000, 1'b0);
            2: apply_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
            default: apply_settings(24'($urandom), 24'($urandom), 24'($urandom),
                                    1'($urandom_range(0, 1)));
         endcase
         // one round with the sender never idling
         sender_idles = (round != 3);
         while (n_random < (round + 1) * ROUND_ITEMS) send_random_sequence();
      end

      wait_for_results();
      repeat (8) @(negedge clock);

      $display("run covered %0d parameters in %0d sequences, %0d extended colours, %0d settings rounds",
               n_params, n_sequences, n_ext, n_settings);
      $display("results compared: %0d, mismatches: %0d", checked_count, fail_count);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
